### rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg: shared definitions for the callback time profiler
// Event codes, field widths and reset value of the sample limit.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] LimitReset = 16'd3000;

  typedef enum logic [ModeW-1:0] {
    MODE_CB_ENTRY = 2'd0,
    MODE_CB_EXIT  = 2'd1,
    MODE_SC_ENTRY = 2'd2,
    MODE_SC_EXIT  = 2'd3
  } mode_e;

  typedef logic [TimeW-1:0]  time_t;
  typedef logic [CountW-1:0] count_t;

endpackage

### rtl/callback_time_profiler.sv
// ----------------------------------------------------------------------------
// callback_time_profiler: per-thread callback and syscall timing profiler
// Tracks callback entry/exit and syscall entry/exit events per thread slot
// and emits one sample (index, response time, syscall time) per callback exit while the count is below the limit.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o| mode_i, thread_slot_i, timestamp_ns_i
//  out     | output    | out_valid_o/out_stall_i| sample_index_o, response_ns_o,
//          |           |                        | syscall_ns_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (sample limit)
//
//  Throughput is one item per cycle unless a callback exit is held by a stalled
//  result. An accepted item sits in the event register, where the slot tables
//  are read, updated and written back in a single pass; a sample lands in the
//  result register at the same edge as that write-back.
//  Reset clears all slot tables, the sample count and both valid flags, and
//  loads the sample limit with 3000. A stalled result holds the event
//  register only when that register carries another callback exit; other
//  events keep flowing.
//
module callback_time_profiler #(
  parameter int unsigned NUM_THREADS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // event input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ctp_pkg::ModeW-1:0]   mode_i,
  input  logic [ctp_pkg::SlotW-1:0]   thread_slot_i,
  input  logic [ctp_pkg::TimeW-1:0]   timestamp_ns_i,
  // sample output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ctp_pkg::CountW-1:0]  sample_index_o,
  output logic [ctp_pkg::TimeW-1:0]   response_ns_o,
  output logic [ctp_pkg::TimeW-1:0]   syscall_ns_o,
  // sample limit register
  input  logic                        cfg_we_i,
  input  logic [ctp_pkg::CountW-1:0]  cfg_wdata_i
);

  // Table index and compare widths follow the slot count.
  localparam int unsigned IdxW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int unsigned CmpW = (IdxW + 1 > ctp_pkg::SlotW) ? IdxW + 1 : ctp_pkg::SlotW;
  localparam logic [CmpW-1:0] NumSlots = CmpW'(NUM_THREADS);

  // --------------------------------------------------------------------------
  // Configuration and sample counter
  // --------------------------------------------------------------------------
  ctp_pkg::count_t limit_q;
  ctp_pkg::count_t count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ctp_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Event register
  // --------------------------------------------------------------------------
  logic                        s1_valid_q;
  ctp_pkg::mode_e              s1_mode_q;
  logic [ctp_pkg::SlotW-1:0]   s1_slot_q;
  ctp_pkg::time_t              s1_ts_q;

  logic in_accept;
  logic s1_advance;
  logic s1_active;
  logic s1_emit;
  logic out_free;
  logic s1_fire;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  // An event that emits a sample must wait for room in the result register.
  assign s1_advance = s1_valid_q && (!s1_emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign s1_fire    = s1_advance && s1_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q <= ctp_pkg::mode_e'(mode_i);
      s1_slot_q <= thread_slot_i;
      s1_ts_q   <= timestamp_ns_i;
    end
  end

  // --------------------------------------------------------------------------
  // Slot tables: read at the event's slot, update, write back in one pass
  // --------------------------------------------------------------------------
  ctp_pkg::time_t cb_start_q [NUM_THREADS];
  ctp_pkg::time_t sc_start_q [NUM_THREADS];
  ctp_pkg::time_t sc_total_q [NUM_THREADS];

  logic [CmpW-1:0] slot_ext;
  logic [IdxW-1:0] idx;
  ctp_pkg::time_t  cb_rd, sc_rd, tot_rd;
  logic            cb_open;

  assign slot_ext = CmpW'(s1_slot_q);
  assign idx      = slot_ext[IdxW-1:0];
  assign cb_rd    = cb_start_q[idx];
  assign sc_rd    = sc_start_q[idx];
  assign tot_rd   = sc_total_q[idx];
  assign cb_open  = (cb_rd != '0);

  // Drop every event once the limit is reached or the slot does not exist.
  assign s1_active = (count_q < limit_q) && (slot_ext < NumSlots);
  assign s1_emit   = s1_active && (s1_mode_q == ctp_pkg::MODE_CB_EXIT);

  logic           cb_we, sc_we, tot_we;
  ctp_pkg::time_t cb_wd, sc_wd, tot_wd;
  ctp_pkg::time_t resp;
  ctp_pkg::time_t sc_dur;

  always_comb begin
    cb_we   = 1'b0;
    sc_we   = 1'b0;
    tot_we  = 1'b0;
    cb_wd   = '0;
    sc_wd   = '0;
    tot_wd  = '0;
    count_d = count_q;
    resp    = cb_open ? (s1_ts_q - cb_rd) : '0;
    sc_dur  = (sc_rd != '0) ? (s1_ts_q - sc_rd) : '0;
    unique case (s1_mode_q)
      ctp_pkg::MODE_CB_ENTRY: begin
        cb_we = 1'b1;
        cb_wd = s1_ts_q;
      end
      ctp_pkg::MODE_CB_EXIT: begin
        // Close the callback: clear start and total, count the sample.
        cb_we   = 1'b1;
        tot_we  = 1'b1;
        count_d = count_q + 1'b1;
      end
      ctp_pkg::MODE_SC_ENTRY: begin
        sc_we = cb_open;
        sc_wd = s1_ts_q;
      end
      ctp_pkg::MODE_SC_EXIT: begin
        // Only a syscall that had a start is consumed.
        sc_we  = cb_open && (sc_rd != '0);
        tot_we = cb_open;
        tot_wd = tot_rd + sc_dur;
      end
      default: begin
        cb_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THREADS; i++) begin
        cb_start_q[i] <= '0;
        sc_start_q[i] <= '0;
        sc_total_q[i] <= '0;
      end
      count_q <= '0;
    end else if (s1_fire) begin
      if (cb_we)  cb_start_q[idx] <= cb_wd;
      if (sc_we)  sc_start_q[idx] <= sc_wd;
      if (tot_we) sc_total_q[idx] <= tot_wd;
      count_q <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic out_load;
  logic out_valid_q;

  assign out_load = s1_fire && s1_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_index_o <= count_q;
      response_ns_o  <= resp;
      syscall_ns_o   <= tot_rd;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The sample counter only ever steps by one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == ctp_pkg::CountW'($past(count_q) + 1'b1)))
    else $error("sample counter moved by more than one");

  // Every counted sample is presented on the output.
  a_count_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> out_valid_q)
    else $error("sample counted without a result");

  // A held event stays in the event register unchanged.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_stall_o) |=> (s1_valid_q && $stable(s1_ts_q) && $stable(s1_slot_q)))
    else $error("held event lost");

endmodule

### verif/tb_callback_time_profiler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_callback_time_profiler: self-checking bench for the callback profiler
// Drives entry/exit events for callbacks and syscalls per thread slot and
// keeps its own copy of the slot tables. Each sample that leaves the block is
// compared field by field with the oldest sample predicted from the accepted
// events. Both channels idle and stall at random. The sample limit is
// rewritten between phases, down to zero, to push the profiler into its
// saturated state.
// ----------------------------------------------------------------------------
module tb_callback_time_profiler;

  localparam int unsigned NumThreads = 16;
  localparam int unsigned StallPct   = 7;
  localparam int unsigned DogLimit   = 2000;

  // One predicted sample, in the order the block emits the fields
  typedef struct packed {
    ctp_pkg::count_t index;
    ctp_pkg::time_t  resp;
    ctp_pkg::time_t  sys;
  } sample_t;

  // Mirror of the profiler: slot tables, sample counter and limit, plus the
  // queue of samples still owed by the block.
  class sample_scoreboard;
    ctp_pkg::time_t  cb_start [NumThreads];
    ctp_pkg::time_t  sc_start [NumThreads];
    ctp_pkg::time_t  sc_total [NumThreads];
    ctp_pkg::count_t count;
    ctp_pkg::count_t limit;
    sample_t         owed_q [$];
    int unsigned     errors;

    function new();
      foreach (cb_start[i]) begin
        cb_start[i] = '0;
        sc_start[i] = '0;
        sc_total[i] = '0;
      end
      count  = '0;
      limit  = ctp_pkg::LimitReset;
      errors = 0;
    endfunction

    function void set_limit(ctp_pkg::count_t value);
      limit = value;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply one accepted event to the mirror
    function void note_event(ctp_pkg::mode_e m, logic [ctp_pkg::SlotW-1:0] slot,
                             ctp_pkg::time_t now);
      logic open;
      if (count >= limit || slot >= NumThreads) return;
      open = (cb_start[slot] != '0);
      case (m)
        ctp_pkg::MODE_CB_ENTRY: cb_start[slot] = now;
        ctp_pkg::MODE_CB_EXIT: begin
          owed_q.push_back('{count, open ? now - cb_start[slot] : '0, sc_total[slot]});
          cb_start[slot] = '0;
          sc_total[slot] = '0;
          count++;
        end
        ctp_pkg::MODE_SC_ENTRY: if (open) sc_start[slot] = now;
        ctp_pkg::MODE_SC_EXIT: begin
          if (open && sc_start[slot] != '0) begin
            sc_total[slot] += now - sc_start[slot];
            sc_start[slot] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one emitted sample against the oldest prediction
    function void check_sample(ctp_pkg::count_t idx, ctp_pkg::time_t resp,
                               ctp_pkg::time_t sys);
      sample_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected sample index=%0d resp=%h sys=%h", idx, resp, sys);
        return;
      end
      want = owed_q.pop_front();
      if (want.index !== idx || want.resp !== resp || want.sys !== sys) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: sample mismatch: expected idx=%0d resp=%h sys=%h, got idx=%0d resp=%h sys=%h",
                   want.index, want.resp, want.sys, idx, resp, sys);
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  ctp_pkg::mode_e             mode = ctp_pkg::MODE_CB_ENTRY;
  logic [ctp_pkg::SlotW-1:0]  thread_slot = '0;
  ctp_pkg::time_t             timestamp_ns = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  ctp_pkg::count_t            sample_index;
  ctp_pkg::time_t             response_ns;
  ctp_pkg::time_t             syscall_ns;
  logic                       cfg_we = 1'b0;
  ctp_pkg::count_t            cfg_wdata = '0;

  // quiet disables idling on both sides for a long stretch
  bit                         quiet = 1'b0;
  ctp_pkg::time_t             clock_ns;
  int unsigned                dog_cycles = 0;
  sample_scoreboard           sb = new();

  always #5 clk_i = ~clk_i;

  callback_time_profiler #(
    .NUM_THREADS(NumThreads)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .thread_slot_i  (thread_slot),
    .timestamp_ns_i (timestamp_ns),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_index_o (sample_index),
    .response_ns_o  (response_ns),
    .syscall_ns_o   (syscall_ns),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Receiver: stall at random on the falling edge, outside quiet stretches
  always @(negedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(99) < StallPct);
  end

  // Check every sample taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_sample(sample_index, response_ns, syscall_ns);
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dog_cycles <= 0;
    end else if (dog_cycles >= DogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      dog_cycles <= dog_cycles + 1;
    end
  end

  // Present one event, hold it until accepted, and note it in the mirror.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_event(ctp_pkg::mode_e m, logic [ctp_pkg::SlotW-1:0] slot,
                            ctp_pkg::time_t ts);
    if (!quiet && $urandom_range(99) < StallPct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid     = 1'b1;
    mode         = m;
    thread_slot  = slot;
    timestamp_ns = ts;
    do @(posedge clk_i); while (in_stall);
    sb.note_event(m, slot, ts);
    @(negedge clk_i);
  endtask

  // Mostly well-formed callback/syscall sequences per slot, with some noise
  task automatic send_random();
    ctp_pkg::mode_e            m;
    logic [ctp_pkg::SlotW-1:0] slot;
    ctp_pkg::time_t            ts;
    int unsigned               roll;
    slot     = $urandom_range(NumThreads - 1);
    roll     = $urandom_range(99);
    clock_ns = clock_ns + $urandom_range(1, 2000);
    ts       = clock_ns;
    if (roll < 12) begin
      m = ctp_pkg::mode_e'(2'($urandom_range(3)));
      case ($urandom_range(3))
        0:       ts = '0;
        1:       ts = {$urandom, $urandom};
        default: ;
      endcase
    end else if (sb.cb_start[slot] == '0) begin
      m = (roll < 95) ? ctp_pkg::MODE_CB_ENTRY : ctp_pkg::MODE_CB_EXIT;
    end else if (sb.sc_start[slot] != '0) begin
      m = (roll < 80) ? ctp_pkg::MODE_SC_EXIT : ctp_pkg::MODE_CB_EXIT;
    end else begin
      m = (roll < 60) ? ctp_pkg::MODE_SC_ENTRY : ctp_pkg::MODE_CB_EXIT;
    end
    send_event(m, slot, ts);
  endtask

  // Hold the sender until every owed sample is out, let the pipe settle,
  // then write the sample limit.
  task automatic write_limit(ctp_pkg::count_t value);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.set_limit(value);
  endtask

  initial begin
    clock_ns = {$urandom, $urandom};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    write_limit(16'hFFFF);

    // Syscalls outside any callback are dropped; an exit with no entry
    // still emits a sample with zero response.
    send_event(ctp_pkg::MODE_SC_ENTRY, 4'd3, 64'd100);
    send_event(ctp_pkg::MODE_SC_EXIT,  4'd3, 64'd200);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd3, 64'd300);
    // Entry at time zero leaves the slot idle
    send_event(ctp_pkg::MODE_CB_ENTRY, 4'd0, 64'd0);
    send_event(ctp_pkg::MODE_SC_ENTRY, 4'd0, 64'd10);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd0, 64'd50);
    // Entry at all ones, syscall exit without entry, syscall entry at zero,
    // then a real syscall and a wrapping response time.
    send_event(ctp_pkg::MODE_CB_ENTRY, 4'd15, '1);
    send_event(ctp_pkg::MODE_SC_EXIT,  4'd15, 64'd3);
    send_event(ctp_pkg::MODE_SC_ENTRY, 4'd15, 64'd0);
    send_event(ctp_pkg::MODE_SC_EXIT,  4'd15, 64'd7);
    send_event(ctp_pkg::MODE_SC_ENTRY, 4'd15, 64'h5555_5555_5555_5555);
    send_event(ctp_pkg::MODE_SC_EXIT,  4'd15, 64'hAAAA_AAAA_AAAA_AAAA);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd15, 64'd5);
    // Callback exit keeps the open syscall start for the next callback
    send_event(ctp_pkg::MODE_CB_ENTRY, 4'd7, 64'd1000);
    send_event(ctp_pkg::MODE_SC_ENTRY, 4'd7, 64'd1100);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd7, 64'd1200);
    send_event(ctp_pkg::MODE_CB_ENTRY, 4'd7, 64'd1300);
    send_event(ctp_pkg::MODE_SC_EXIT,  4'd7, 64'd1500);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd7, 64'd1600);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd7, 64'd1700);
    // Syscall duration that wraps through zero
    send_event(ctp_pkg::MODE_CB_ENTRY, 4'd9, 64'h8000_0000_0000_0000);
    send_event(ctp_pkg::MODE_SC_ENTRY, 4'd9, 64'h8000_0000_0000_0001);
    send_event(ctp_pkg::MODE_SC_EXIT,  4'd9, 64'd0);
    send_event(ctp_pkg::MODE_CB_EXIT,  4'd9, 64'd12);

    // Main random body, with a long stretch free of idling in the middle
    for (int i = 0; i < 600; i++) begin
      quiet = (i >= 200 && i < 400);
      send_random();
    end
    quiet = 1'b0;

    // Drop the limit just above the current count so the block saturates
    write_limit(sb.count + 16'd8);
    repeat (150) send_random();

    // Zero limit: everything ignored
    write_limit('0);
    repeat (25) send_random();

    // Limit of one, already exceeded by the count
    write_limit(16'd1);
    repeat (20) send_random();

    // Back to the reset value, with time close to wrapping around
    write_limit(ctp_pkg::LimitReset);
    clock_ns = '1 - 64'd200000;
    repeat (650) send_random();

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
